[rtl/jtps_pkg.sv]
// Shared types and constants for the permutation step unit.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package jtps_pkg;

	localparam int WORD_W = 32;
	localparam int SIZE_W = 4;
	localparam int APB_DW = 32;
	localparam int APB_AW = 3;
	localparam int NIB_W  = 4;

	// Register index, taken from paddr[2].
	localparam logic REG_SIZE = 1'b0;

	typedef struct packed {
		logic capture;
		logic restart;
		logic step;
	} dp_cmd_t;

endpackage

`default_nettype wire

[rtl/johnson_trotter_permutation_step_unit.sv]
// Top level: Johnson-Trotter permutation step unit with APB size register.
// Depends on jtps_pkg, jtps_ctrl and jtps_dp.
// A restart item gives its result in the cycle after acceptance; an advance item passes through the
// search state, with the mobility flags captured on acceptance, and stalls new items until it is done.
// One restart item per cycle while result_stall is low.
// Reset: size 8, identity permutation, all arrows left, no result pending.
`timescale 1ns / 1ps
`default_nettype none

module johnson_trotter_permutation_step_unit #(
	parameter int MAX_SIZE = 8
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          psel,
	input  wire                          penable,
	input  wire                          pwrite,
	input  wire [jtps_pkg::APB_AW-1:0]   paddr,
	input  wire [jtps_pkg::APB_DW-1:0]   pwdata,
	output logic [jtps_pkg::APB_DW-1:0]  prdata,
	output logic                         pready,
	input  wire                          item_valid,
	output logic                         item_stall,
	input  wire                          restart,
	output logic                         result_valid,
	input  wire                          result_stall,
	output logic [jtps_pkg::WORD_W-1:0]  perm_word,
	output logic                         final_res
);

	import jtps_pkg::*;

	dp_cmd_t           cmd;
	logic              cfg_wr;
	logic [SIZE_W-1:0] size_val;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_SIZE);
	assign prdata = (paddr[2] == REG_SIZE) ? APB_DW'(size_val) : '0;

	jtps_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.restart      (restart),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.cmd          (cmd)
	);

	jtps_dp #(
		.MAX_SIZE (MAX_SIZE)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cfg_wr    (cfg_wr),
		.cfg_size  (pwdata[SIZE_W-1:0]),
		.size_val  (size_val),
		.perm_word (perm_word),
		.final_res (final_res)
	);

endmodule

`default_nettype wire

[rtl/jtps_dp.sv]
// Datapath: permutation values, arrows, size register, mobility search and result word.
// Depends on jtps_pkg.
`timescale 1ns / 1ps
`default_nettype none

module jtps_dp #(
	parameter int MAX_SIZE = 8
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  jtps_pkg::dp_cmd_t            cmd,
	input  wire                          cfg_wr,
	input  wire [jtps_pkg::SIZE_W-1:0]   cfg_size,
	output logic [jtps_pkg::SIZE_W-1:0]  size_val,
	output logic [jtps_pkg::WORD_W-1:0]  perm_word,
	output logic                         final_res
);

	import jtps_pkg::*;

	localparam int VW = $clog2(MAX_SIZE + 1);
	localparam int CW = (VW > SIZE_W) ? VW : SIZE_W;
	localparam int PK = (MAX_SIZE < 8) ? MAX_SIZE : 8;
	localparam int LV = $clog2(MAX_SIZE);
	localparam int L  = 2 ** LV;

	typedef logic [MAX_SIZE-1:0][VW-1:0] perm_t;

	logic [SIZE_W-1:0] size_q;
	logic [VW-1:0]     n_q;
	perm_t             perm_q;
	logic [MAX_SIZE-1:0] arr_q;
	logic [MAX_SIZE-1:0] mob_q;
	logic [WORD_W-1:0] word_q;
	logic              final_q;

	logic [MAX_SIZE-1:0] mob;
	logic [VW-1:0]       tv [0:LV][0:L-1];
	logic [VW-1:0]       maxv;
	logic                found;
	logic [MAX_SIZE-1:0] best;
	perm_t               nv;
	logic [MAX_SIZE-1:0] na;

	function automatic logic [VW-1:0] eff_n(input logic [SIZE_W-1:0] s);
		logic [CW-1:0] w;
		w = CW'(s);
		if (w == '0) w = CW'(1);
		if (w > CW'(MAX_SIZE)) w = CW'(MAX_SIZE);
		return w[VW-1:0];
	endfunction

	function automatic perm_t ident(input logic [VW-1:0] n);
		perm_t p;
		for (int i = 0; i < MAX_SIZE; i++) begin
			p[i] = (VW'(i) < n) ? VW'(i + 1) : '0;
		end
		return p;
	endfunction

	function automatic logic [WORD_W-1:0] pack(input perm_t p);
		logic [WORD_W-1:0] w;
		logic [CW-1:0]     t;
		w = '0;
		for (int i = 0; i < PK; i++) begin
			t = CW'(p[i]);
			w[NIB_W*i +: NIB_W] = t[NIB_W-1:0];
		end
		return w;
	endfunction

	always_comb begin
		for (int i = 0; i < MAX_SIZE; i++) begin
			mob[i] = 1'b0;
			if (!arr_q[i]) begin
				if (i != 0) mob[i] = perm_q[i-1] < perm_q[i];
			end else begin
				if (i + 1 < MAX_SIZE)
					mob[i] = (VW'(i + 1) < n_q) && (perm_q[i+1] < perm_q[i]);
			end
		end
	end

	always_comb begin
		for (int k = 0; k <= LV; k++) begin
			for (int j = 0; j < L; j++) begin
				tv[k][j] = '0;
			end
		end
		for (int j = 0; j < MAX_SIZE; j++) begin
			tv[0][j] = mob_q[j] ? perm_q[j] : '0;
		end
		for (int k = 0; k < LV; k++) begin
			for (int j = 0; j < (L >> (k + 1)); j++) begin
				tv[k+1][j] = (tv[k][2*j] > tv[k][2*j+1]) ? tv[k][2*j] : tv[k][2*j+1];
			end
		end
		maxv  = tv[LV][0];
		found = maxv != '0;
	end

	always_comb begin
		for (int i = 0; i < MAX_SIZE; i++) begin
			best[i] = found && mob_q[i] && (perm_q[i] == maxv);
		end
		for (int i = 0; i < MAX_SIZE; i++) begin
			nv[i] = perm_q[i];
			na[i] = arr_q[i];
			if (best[i]) begin
				if (arr_q[i]) begin
					if (i + 1 < MAX_SIZE) begin
						nv[i] = perm_q[i+1];
						na[i] = arr_q[i+1];
					end
				end else begin
					if (i != 0) begin
						nv[i] = perm_q[i-1];
						na[i] = arr_q[i-1];
					end
				end
			end
			if (i != 0) begin
				if (best[i-1] && arr_q[i-1]) begin
					nv[i] = perm_q[i-1];
					na[i] = arr_q[i-1];
				end
			end
			if (i + 1 < MAX_SIZE) begin
				if (best[i+1] && !arr_q[i+1]) begin
					nv[i] = perm_q[i+1];
					na[i] = arr_q[i+1];
				end
			end
			na[i] = na[i] ^ (nv[i] > maxv);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q  <= SIZE_W'(8);
			n_q     <= eff_n(SIZE_W'(8));
			perm_q  <= ident(eff_n(SIZE_W'(8)));
			arr_q   <= '0;
			final_q <= 1'b0;
		end else if (cfg_wr) begin
			size_q <= cfg_size;
			n_q    <= eff_n(cfg_size);
			perm_q <= ident(eff_n(cfg_size));
			arr_q  <= '0;
		end else if (cmd.capture) begin
			final_q <= 1'b0;
			if (cmd.restart) begin
				perm_q <= ident(n_q);
				arr_q  <= '0;
			end
		end else if (cmd.step) begin
			final_q <= !found;
			if (found) begin
				perm_q <= nv;
				arr_q  <= na;
			end else begin
				perm_q <= ident(n_q);
				arr_q  <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			word_q <= cmd.restart ? pack(ident(n_q)) : pack(perm_q);
			mob_q  <= mob;
		end
	end

	assign size_val  = size_q;
	assign perm_word = word_q;
	assign final_res = final_q;

endmodule

`default_nettype wire

[rtl/jtps_ctrl.sv]
// Controller: item handshakes, search sequencing and result valid.
// Depends on jtps_pkg.
`timescale 1ns / 1ps
`default_nettype none

module jtps_ctrl (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                item_valid,
	output logic               item_stall,
	input  wire                restart,
	output logic               result_valid,
	input  wire                result_stall,
	output jtps_pkg::dp_cmd_t  cmd
);

	import jtps_pkg::*;

	localparam logic ST_IDLE   = 1'b0;
	localparam logic ST_SEARCH = 1'b1;

	logic state_q;
	logic res_valid_q;
	logic accept;

	assign item_stall = !((state_q == ST_IDLE) && (!res_valid_q || !result_stall));
	assign accept     = item_valid && !item_stall;

	assign cmd.capture = accept;
	assign cmd.restart = restart;
	assign cmd.step    = state_q == ST_SEARCH;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (res_valid_q && !result_stall) res_valid_q <= 1'b0;
					if (accept) begin
						if (restart) res_valid_q <= 1'b1;
						else state_q <= ST_SEARCH;
					end
				end
				ST_SEARCH: begin
					res_valid_q <= 1'b1;
					state_q     <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign result_valid = res_valid_q;

endmodule

`default_nettype wire
